/* src/time_bucketed_xmin_ring_defines.svh */
// Assertion macros shared by the watermark ring RTL.
// Used by files that carry concurrent checks; depends on nothing else.
`ifndef TIME_BUCKETED_XMIN_RING_DEFINES_SVH
`define TIME_BUCKETED_XMIN_RING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBXR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbxr check failed");

// The consequent must hold in the cycle after the antecedent.
`define TBXR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbxr check failed");

`endif

/* src/tbxr_pkg.sv */
// Shared types and constants of the watermark ring block.
// Used by every module of the block but the RAM; depends on nothing.
package tbxr_pkg;

  localparam int RingDepth = 64;  // must be a power of two
  localparam int SlotW     = $clog2(RingDepth);

  localparam int OpW     = 2;
  localparam int StampW  = 63;
  localparam int IdW     = 32;
  localparam int SecW    = 34;
  localparam int StatusW = 2;

  localparam int S_TDATA_W = ((StampW + IdW + 7) / 8) * 8;
  localparam int M_TDATA_W = IdW;
  localparam int M_TUSER_W = 1 + StatusW;

  localparam longint NsPerSecond = 64'd1000000000;

  // One second is a power of two times an odd factor. The stamp drops the power
  // of two and is divided by the odd factor through a truncated reciprocal, whose
  // estimate is at most one below the true quotient.
  localparam int     DivShift = 9;
  localparam longint DivOdd   = NsPerSecond >> DivShift;
  localparam int     DivOddW  = $clog2(DivOdd);
  localparam int     DivXW    = StampW - DivShift;
  localparam longint DivRecip = (longint'(1) << DivXW) / DivOdd;
  localparam int     DivXLoW  = DivXW / 2;
  localparam int     DivXHiW  = DivXW - DivXLoW;
  localparam int     DivRLoW  = SecW / 2;
  localparam int     DivOpAW  = DivXHiW;
  localparam int     DivOpBW  = DivOddW;
  localparam int     DivProdW = DivOpAW + DivOpBW;
  localparam int     DivAccW  = DivXW + SecW;
  localparam int     DivRemW  = DivOddW + 1;
  localparam int     DivSteps = 8;
  localparam int     DivCntW  = $clog2(DivSteps);

  typedef enum logic [OpW-1:0] {
    OP_RECORD = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_FILL   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    LK_FOUND   = 2'd0,
    LK_FUTURE  = 2'd1,
    LK_TOO_OLD = 2'd2
  } lk_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EVAL,
    ST_REC_HEAD,
    ST_REC_GAP,
    ST_REC_TAIL,
    ST_READ_DATA,
    ST_FILL,
    ST_RESULT
  } state_e;

  typedef enum logic [DivCntW-1:0] {
    DIV_XL_RL = 3'd0,
    DIV_XL_RH = 3'd1,
    DIV_XH_RL = 3'd2,
    DIV_XH_RH = 3'd3,
    DIV_QUOT  = 3'd4,
    DIV_QL_D  = 3'd5,
    DIV_QH_D  = 3'd6,
    DIV_FIX   = 3'd7
  } div_step_e;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic eval_rec;
    logic eval_lk;
    logic rd_slot;
    logic rd_next;
    logic rec_write_head;
    logic gap_write;
    logic take_rdata;
    logic fill;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rec_newer;
    logic lk_future;
    logic lk_near;
    logic gap_zero;
    logic gap_one;
    logic out_free;
  } sts_t;

endpackage

/* src/tbxr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the watermark ring; depends on nothing.
module tbxr_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tbxr_div.sv */
// Divider of a nanosecond stamp by one second through a reciprocal multiply.
// One narrow multiplier is shared across the multiply steps; depends on tbxr_pkg.
module tbxr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tbxr_pkg::StampW-1:0] stamp_i,
  output logic                        done_o,
  output logic [tbxr_pkg::SecW-1:0]   quot_o
);
  import tbxr_pkg::*;

  logic [DivXW-1:0]    x_q;
  logic [DivAccW-1:0]  acc_q, acc_d;
  logic [SecW-1:0]     quo_q, quo_d;
  div_step_e           step_q;
  logic                busy_q;
  logic                done_q;
  logic [DivOpAW-1:0]  op_a;
  logic [DivOpBW-1:0]  op_b;
  logic [DivProdW-1:0] prod;
  logic [DivRemW-1:0]  rem;
  logic [SecW-1:0]     recip;

  assign recip = SecW'(DivRecip);
  assign prod  = op_a * op_b;
  // The true remainder of the estimate is below twice the divisor, so its low
  // bits are enough.
  assign rem   = x_q[DivRemW-1:0] - acc_q[DivRemW-1:0];

  // The first four steps build stamp times reciprocal from partial products, the
  // fifth takes the estimate, the next two multiply it back, the last corrects it.
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    acc_d = acc_q;
    quo_d = quo_q;
    unique case (step_q)
      DIV_XL_RL: begin
        op_a  = DivOpAW'(x_q[DivXLoW-1:0]);
        op_b  = DivOpBW'(recip[DivRLoW-1:0]);
        acc_d = acc_q + DivAccW'(prod);
      end
      DIV_XL_RH: begin
        op_a  = DivOpAW'(x_q[DivXLoW-1:0]);
        op_b  = DivOpBW'(recip[SecW-1:DivRLoW]);
        acc_d = acc_q + (DivAccW'(prod) << DivRLoW);
      end
      DIV_XH_RL: begin
        op_a  = DivOpAW'(x_q[DivXW-1:DivXLoW]);
        op_b  = DivOpBW'(recip[DivRLoW-1:0]);
        acc_d = acc_q + (DivAccW'(prod) << DivXLoW);
      end
      DIV_XH_RH: begin
        op_a  = DivOpAW'(x_q[DivXW-1:DivXLoW]);
        op_b  = DivOpBW'(recip[SecW-1:DivRLoW]);
        acc_d = acc_q + (DivAccW'(prod) << (DivXLoW + DivRLoW));
      end
      DIV_QUOT: begin
        quo_d = acc_q[DivXW +: SecW];
        acc_d = '0;
      end
      DIV_QL_D: begin
        op_a  = DivOpAW'(quo_q[DivRLoW-1:0]);
        op_b  = DivOpBW'(DivOdd);
        acc_d = acc_q + DivAccW'(prod);
      end
      DIV_QH_D: begin
        op_a  = DivOpAW'(quo_q[SecW-1:DivRLoW]);
        op_b  = DivOpBW'(DivOdd);
        acc_d = acc_q + (DivAccW'(prod) << DivRLoW);
      end
      DIV_FIX: begin
        if (rem >= DivRemW'(DivOdd)) begin
          quo_d = quo_q + 1'b1;
        end
      end
      default: begin
        quo_d = quo_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= DIV_XL_RL;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= DIV_XL_RL;
    end else if (busy_q) begin
      step_q <= div_step_e'(step_q + 1'b1);
      if (step_q == DIV_FIX) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= stamp_i[StampW-1:DivShift];
      acc_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* src/tbxr_ctrl.sv */
// Controller state machine of the watermark ring block.
// Drives datapath commands from the operation and datapath status; uses tbxr_pkg.
module tbxr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [tbxr_pkg::OpW-1:0] in_op_i,
  input  tbxr_pkg::sts_t           sts_i,
  output logic                     in_ready_o,
  output tbxr_pkg::cmd_t           cmd_o
);
  import tbxr_pkg::*;

  state_e state_q, state_d;
  op_e    op_q;
  op_e    in_op;
  logic   accept;

  assign in_op  = op_e'(in_op_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NOP;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q <= in_op;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op) inside
            OP_RECORD, OP_LOOKUP: state_d = ST_DIVIDE;
            OP_FILL:              state_d = ST_FILL;
            default:              state_d = ST_RESULT;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (op_q == OP_RECORD) begin
          state_d = sts_i.rec_newer ? ST_REC_HEAD : ST_RESULT;
        end else begin
          state_d = (sts_i.lk_future || sts_i.lk_near) ? ST_READ_DATA : ST_RESULT;
        end
      end
      ST_REC_HEAD:  state_d = sts_i.gap_zero ? ST_REC_TAIL : ST_REC_GAP;
      ST_REC_GAP: begin
        if (sts_i.gap_one) begin
          state_d = ST_REC_TAIL;
        end
      end
      ST_REC_TAIL:  state_d = ST_READ_DATA;
      ST_READ_DATA: state_d = ST_RESULT;
      ST_FILL:      state_d = ST_RESULT;
      ST_RESULT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load_in    = accept;
        cmd_o.div_start  = accept && (in_op == OP_RECORD || in_op == OP_LOOKUP);
      end
      ST_EVAL: begin
        cmd_o.eval_rec = (op_q == OP_RECORD);
        cmd_o.eval_lk  = (op_q == OP_LOOKUP);
        // A lookup that is not for a future second reads its own slot;
        // otherwise the default read address is the head slot.
        cmd_o.rd_slot  = (op_q == OP_LOOKUP) && !sts_i.lk_future;
      end
      ST_REC_HEAD:  cmd_o.rec_write_head = 1'b1;
      ST_REC_GAP:   cmd_o.gap_write      = 1'b1;
      ST_REC_TAIL:  cmd_o.rd_next        = 1'b1;
      ST_READ_DATA: cmd_o.take_rdata     = 1'b1;
      ST_FILL:      cmd_o.fill           = 1'b1;
      ST_RESULT:    cmd_o.emit           = sts_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* src/tbxr_dp.sv */
// Datapath of the watermark ring: divider, ring RAM, head and second registers,
// result staging and output register. Uses tbxr_pkg, tbxr_div and tbxr_ram.
`include "time_bucketed_xmin_ring_defines.svh"

module tbxr_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tbxr_pkg::cmd_t                 cmd_i,
  input  logic [tbxr_pkg::StampW-1:0]    in_stamp_i,
  input  logic [tbxr_pkg::IdW-1:0]       in_id_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [tbxr_pkg::IdW-1:0]       out_xid_o,
  output logic                           out_updated_o,
  output logic [tbxr_pkg::StatusW-1:0]   out_status_o,
  output tbxr_pkg::sts_t                 sts_o
);
  import tbxr_pkg::*;

  logic             div_done;
  logic [SecW-1:0]  quot;

  logic [IdW-1:0]   id_q;
  logic [SecW-1:0]  sec_q;
  logic [SecW-1:0]  last_q;
  logic [SlotW-1:0] head_q;
  logic [SlotW-1:0] pos_q;
  logic [SlotW-1:0] gap_cnt_q;
  logic [IdW-1:0]   prev_q;
  logic [IdW-1:0]   fill_val_q;
  logic [RingDepth-1:0] valid_q;
  logic             valid_rd_q;

  logic [IdW-1:0]   res_xid_q;
  logic             res_upd_q;
  lk_status_e       res_status_q;

  logic             m_valid_q;
  logic [IdW-1:0]   m_xid_q;
  logic             m_upd_q;
  logic [StatusW-1:0] m_status_q;

  logic [SecW-1:0]  sec_rec;
  logic [SecW:0]    rec_diff;
  logic [SecW:0]    lk_diff;
  logic             rec_newer;
  logic             rec_big;
  logic             lk_future;
  logic             lk_near;

  logic             ram_we;
  logic [SlotW-1:0] ram_waddr;
  logic [IdW-1:0]   ram_wdata;
  logic [SlotW-1:0] ram_raddr;
  logic [IdW-1:0]   ram_rdata;
  logic [IdW-1:0]   rd_eff;
  logic             out_free;

  tbxr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .stamp_i (in_stamp_i),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  tbxr_ram #(
    .Width (IdW),
    .Depth (RingDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A record rounds up to the next second; a lookup rounds down.
  assign sec_rec   = quot + 1'b1;
  assign rec_diff  = {1'b0, sec_rec} - {1'b0, last_q};
  assign lk_diff   = {1'b0, last_q} - {1'b0, quot};
  assign rec_newer = !rec_diff[SecW] && (rec_diff[SecW-1:0] != '0);
  assign rec_big   = rec_diff[SecW-1:0] >= SecW'(RingDepth);
  assign lk_future = lk_diff[SecW];
  assign lk_near   = !lk_diff[SecW] && (lk_diff[SecW-1:0] < SecW'(RingDepth));

  assign ram_we    = cmd_i.rec_write_head || cmd_i.gap_write;
  assign ram_waddr = cmd_i.rec_write_head ? sec_q[SlotW-1:0] : pos_q;
  assign ram_wdata = cmd_i.rec_write_head ? id_q : prev_q;
  assign ram_raddr = cmd_i.rd_next ? head_q + 1'b1 :
                     cmd_i.rd_slot ? quot[SlotW-1:0] : head_q;

  // A slot not written since reset or the last fill holds the fill value.
  assign rd_eff   = valid_rd_q ? ram_rdata : fill_val_q;
  assign out_free = !m_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      last_q     <= '0;
      valid_q    <= '0;
      fill_val_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.rec_write_head) begin
        head_q <= sec_q[SlotW-1:0];
        last_q <= sec_q;
      end
      if (cmd_i.fill) begin
        valid_q    <= '0;
        fill_val_q <= id_q;
      end else if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    valid_rd_q <= valid_q[ram_raddr];
    if (cmd_i.load_in) begin
      id_q         <= in_id_i;
      res_xid_q    <= '0;
      res_upd_q    <= 1'b0;
      res_status_q <= LK_FOUND;
    end
    if (cmd_i.eval_rec) begin
      sec_q     <= sec_rec;
      gap_cnt_q <= rec_big ? SlotW'(RingDepth - 1) : rec_diff[SlotW-1:0] - 1'b1;
      res_upd_q <= rec_newer;
    end
    if (cmd_i.eval_lk) begin
      res_status_q <= lk_future ? LK_FUTURE : (lk_near ? LK_FOUND : LK_TOO_OLD);
    end
    if (cmd_i.rec_write_head) begin
      prev_q <= rd_eff;
      pos_q  <= sec_q[SlotW-1:0] - 1'b1;
    end
    if (cmd_i.gap_write) begin
      pos_q     <= pos_q - 1'b1;
      gap_cnt_q <= gap_cnt_q - 1'b1;
    end
    if (cmd_i.take_rdata) begin
      res_xid_q <= rd_eff;
    end
    if (cmd_i.emit) begin
      m_xid_q    <= res_xid_q;
      m_upd_q    <= res_upd_q;
      m_status_q <= res_status_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.div_done  = div_done;
    sts_o.rec_newer = rec_newer;
    sts_o.lk_future = lk_future;
    sts_o.lk_near   = lk_near;
    sts_o.gap_zero  = (gap_cnt_q == '0);
    sts_o.gap_one   = (gap_cnt_q == SlotW'(1));
    sts_o.out_free  = out_free;
  end

  assign out_valid_o   = m_valid_q;
  assign out_xid_o     = m_xid_q;
  assign out_updated_o = m_upd_q;
  assign out_status_o  = m_status_q;

  `TBXR_ASSERT_SAME(a_emit_free, clk_i, rst_ni, cmd_i.emit, out_free)
  `TBXR_ASSERT_NEXT(a_fill_clears, clk_i, rst_ni, cmd_i.fill, valid_q == '0)
  `TBXR_ASSERT_NEXT(a_write_valid, clk_i, rst_ni, ram_we, valid_q[$past(ram_waddr)])
  `TBXR_ASSERT_SAME(a_gap_nonzero, clk_i, rst_ni, cmd_i.gap_write, gap_cnt_q != '0)

endmodule

/* src/time_bucketed_xmin_ring.sv */
// Watermark ring, one slot per second, one item in work at a time. Records and lookups
// run the stamp divider first; a record that moves head then writes its slot and g skipped
// slots (0..63), and a lookup that is too old or a covered record skips the ring read. Fills
// and unused opcodes skip the divider. The next item is accepted once its result is registered
// and the controller is idle again, and a stalled result holds the next one in its last step.
// Reset clears head, last second, slot valid bits and the fill value; the ring reads as zero.
module time_bucketed_xmin_ring (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tbxr_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // stamp_ns, oldest_id, pad
  input  logic [tbxr_pkg::OpW-1:0]          s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tbxr_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // xid_out
  output logic [tbxr_pkg::M_TUSER_W-1:0]    m_axis_tuser   // updated, lookup_status
);
  import tbxr_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [IdW-1:0]     out_xid;
  logic               out_upd;
  logic [StatusW-1:0] out_status;

  tbxr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  tbxr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_stamp_i    (s_axis_tdata[StampW-1:0]),
    .in_id_i       (s_axis_tdata[StampW+IdW-1:StampW]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_xid_o     (out_xid),
    .out_updated_o (out_upd),
    .out_status_o  (out_status),
    .sts_o         (sts)
  );

  assign m_axis_tdata = out_xid;
  assign m_axis_tuser = {out_status, out_upd};

endmodule

/* verif/time_bucketed_xmin_ring_test.sv */
// Self-checking bench for the per-second watermark ring: records, lookups, fills and unused ops.
// Depends on tbxr_pkg and the time_bucketed_xmin_ring top; an internal shadow ring predicts results.
`timescale 1ns / 1ps

module time_bucketed_xmin_ring_test;
  import tbxr_pkg::*;

  localparam int RandomItems = 1050;
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 100;

  typedef struct packed {
    op_e             op;
    logic [StampW-1:0] stamp;
    logic [IdW-1:0]  id;
  } ring_request_t;

  typedef struct packed {
    logic [IdW-1:0] xid;
    logic           updated;
    lk_status_e     status;
  } ring_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // stamp_ns, oldest_id, pad
  logic [OpW-1:0] s_axis_tuser = OP_NOP;    // op
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // xid_out
  logic [M_TUSER_W-1:0] m_axis_tuser;       // updated, lookup_status

  time_bucketed_xmin_ring DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  ring_request_t ring_requests[$];
  ring_answer_t  answer_queue[$];
  ring_request_t on_bus;
  int total_items;
  int sent_items;
  int mismatches;
  int unsigned cycles;

  // Shadow copy of the block state.
  logic [IdW-1:0]  shadow_ring [RingDepth];
  int unsigned     shadow_head;
  logic [SecW-1:0] shadow_last;

  int n_record, n_moved, n_lookup, n_fill, n_nop;
  int n_status [3];

  // Latest second a record in the planned stimulus will have moved head to.
  longint unsigned planned_last;

  function automatic ring_answer_t ring_answer(ring_request_t rq);
    ring_answer_t    a;
    logic [63:0]     whole;
    logic [SecW-1:0] sec;
    logic [SecW-1:0] gap;
    logic [IdW-1:0]  prev;
    int unsigned     pos;
    a = '0;
    whole = {1'b0, rq.stamp} / 64'(NsPerSecond);
    case (rq.op)
      OP_RECORD: begin
        n_record++;
        // Records round up: the second after the one the stamp falls in.
        sec = whole[SecW-1:0] + 1'b1;
        if (sec > shadow_last) begin
          n_moved++;
          prev = shadow_ring[shadow_head];
          gap = sec - shadow_last;
          if (gap > RingDepth) gap = SecW'(RingDepth);
          shadow_last = sec;
          pos = 32'(sec % RingDepth);
          shadow_head = pos;
          shadow_ring[pos] = rq.id;
          for (int k = 1; k < gap; k++) begin
            pos = (pos + RingDepth - 1) % RingDepth;
            shadow_ring[pos] = prev;
          end
          a.xid = shadow_ring[(shadow_head + 1) % RingDepth];
          a.updated = 1'b1;
        end
      end
      OP_LOOKUP: begin
        n_lookup++;
        sec = whole[SecW-1:0];
        if (sec > shadow_last) begin
          a.xid = shadow_ring[shadow_head];
          a.status = LK_FUTURE;
        end else if (shadow_last - sec < RingDepth) begin
          a.xid = shadow_ring[sec % RingDepth];
          a.status = LK_FOUND;
        end else begin
          a.status = LK_TOO_OLD;
        end
        n_status[a.status]++;
      end
      OP_FILL: begin
        n_fill++;
        foreach (shadow_ring[i]) shadow_ring[i] = rq.id;
      end
      default: n_nop++;
    endcase
    return a;
  endfunction

  function automatic int idle_share(bit sender);
    int phase;
    phase = (sent_items < total_items / 3) ? 0 : (sent_items < 2 * total_items / 3) ? 1 : 2;
    if (phase == 2) return 0;
    return ((phase == 0) == sender) ? 16 : 64;
  endfunction

  // Sender side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= OP_NOP;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        answer_queue.push_back(ring_answer(on_bus));
        sent_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (ring_requests.size() > 0 && $urandom_range(99) >= idle_share(1'b1)) begin
          on_bus = ring_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= S_TDATA_W'({on_bus.id, on_bus.stamp});
          s_axis_tuser <= on_bus.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side and result check.
  always @(posedge clk_i or negedge rst_ni) begin
    ring_answer_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: xid %h updated %0d status %0d",
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1]);
        end else begin
          want = answer_queue.pop_front();
          if (m_axis_tdata !== want.xid || m_axis_tuser[0] !== want.updated ||
              m_axis_tuser[2:1] !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: xid exp %h got %h, updated exp %0d got %0d, %s",
                       want.xid, m_axis_tdata, want.updated, m_axis_tuser[0],
                       $sformatf("status exp %0d got %0d", want.status,
                                 m_axis_tuser[2:1]));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_share(1'b0));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout with %0d items queued and %0d results outstanding",
               ring_requests.size(), answer_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void add_item(op_e op, logic [StampW-1:0] stamp, logic [IdW-1:0] id);
    ring_request_t   rq;
    longint unsigned sec;
    rq.op = op;
    rq.stamp = stamp;
    rq.id = id;
    ring_requests.push_back(rq);
    if (op == OP_RECORD) begin
      sec = {1'b0, stamp} / 64'(NsPerSecond) + 1;
      if (sec > planned_last) planned_last = sec;
    end
  endfunction

  function automatic logic [StampW-1:0] stamp_at(longint unsigned sec);
    int r;
    longint unsigned offset;
    r = $urandom_range(9);
    offset = (r == 0) ? 0 : (r == 1) ? 999999999 : $urandom_range(999999999);
    return StampW'(sec * 64'(NsPerSecond) + offset);
  endfunction

  function automatic logic [IdW-1:0] random_id();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return '1;
    return $urandom;
  endfunction

  // A record that lands in second t is stamped inside second t - 1.
  function automatic void add_record(longint signed target);
    if (target < 1) target = 1;
    add_item(OP_RECORD, stamp_at(target - 1), random_id());
  endfunction

  function automatic void add_lookup(longint signed sec);
    if (sec < 0) sec = 0;
    add_item(OP_LOOKUP, stamp_at(sec), random_id());
  endfunction

  initial begin
    int pick;
    int r;
    int d;
    longint signed last;
    planned_last = 0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    shadow_head = 0;
    shadow_last = '0;

    // Directed part.
    add_item(OP_LOOKUP, '0, '0);                   // lookup at reset state
    add_item(OP_RECORD, '0, 32'h0000_0011);        // first record after reset
    add_item(OP_RECORD, StampW'(999999999), '1);   // same second again: covered
    add_item(OP_LOOKUP, StampW'(64'd5000000000), '0);  // future second
    add_item(OP_RECORD, StampW'(64'd2000000000), '1);  // skips one slot
    add_lookup(2);
    add_item(OP_FILL, '0, 32'hA5A5_A5A5);
    add_item(OP_NOP, '1, '1);
    add_item(OP_RECORD, StampW'(64'd199000000000), '0);  // gap beyond the ring depth
    add_lookup(136);                               // just too old
    add_lookup(137);                               // oldest slot still held
    add_lookup(200);
    add_lookup(201);
    add_record(200 + RingDepth);                   // gap of exactly the depth
    add_record(201 + RingDepth);
    add_item(OP_FILL, '0, '0);
    add_item(OP_FILL, '0, '1);
    add_item(OP_LOOKUP, '1, '0);                   // largest stamp
    add_item(OP_LOOKUP, '0, '1);
    add_record(5);                                 // older second: covered
    add_item(OP_NOP, '0, '0);

    // Random part: mostly advancing records with lookups around head.
    for (int n = 0; n < RandomItems; ) begin
      pick = $urandom_range(99);
      last = longint'(planned_last);
      if (pick < 62) begin
        r = $urandom_range(99);
        if (r < 55) d = $urandom_range(1, 3);
        else if (r < 68) d = 0;
        else if (r < 78) d = -$urandom_range(1, 80);
        else if (r < 93) d = $urandom_range(4, 70);
        else d = $urandom_range(71, 400);
        add_record(last + d);
        n++;
        repeat ($urandom_range(2)) begin
          add_lookup(longint'(planned_last) + $urandom_range(74) - 70);
          n++;
        end
      end else if (pick < 74) begin
        add_lookup(last + $urandom_range(74) - 70);
        n++;
      end else if (pick < 82) begin
        add_item(OP_LOOKUP, StampW'({$urandom, $urandom}), $urandom);
        n++;
      end else if (pick < 87) begin
        add_item(OP_FILL, StampW'({$urandom, $urandom}), random_id());
        n++;
      end else if (pick < 91) begin
        add_item(OP_NOP, StampW'({$urandom, $urandom}), $urandom);
        n++;
      end else begin
        // Edges of the window kept in the ring.
        r = $urandom_range(3);
        add_lookup((r == 0) ? last - RingDepth : (r == 1) ? last - RingDepth + 1 :
                   (r == 2) ? last : last + 1);
        n++;
      end
    end

    // The largest stamp moves head to the last possible second, so it goes last.
    add_item(OP_RECORD, '1, $urandom);
    add_item(OP_LOOKUP, '1, '0);
    add_item(OP_LOOKUP, '0, '0);
    total_items = ring_requests.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (ring_requests.size() != 0 || s_axis_tvalid || answer_queue.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d items: %0d records (%0d moved head), %0d fills, %0d unused ops.",
             sent_items, n_record, n_moved, n_fill, n_nop);
    $display("Lookups %0d: %0d found, %0d past head, %0d too old; %0d mismatches.",
             n_lookup, n_status[LK_FOUND], n_status[LK_FUTURE], n_status[LK_TOO_OLD],
             mismatches);
    if (mismatches == 0 && answer_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/tbxr_pkg.sv
src/tbxr_ram.sv
src/tbxr_div.sv
src/tbxr_ctrl.sv
src/tbxr_dp.sv
src/time_bucketed_xmin_ring.sv
verif/time_bucketed_xmin_ring_test.sv
